// ===== src/mtq_pkg.sv =====
`timescale 1ns / 1ps

package mtq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_W          = 16;
    localparam int DELAY_W       = 24;
    localparam int CNT_W         = 5;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func FUNC_ADD    = 2'd0;
    localparam t_func FUNC_REMOVE = 2'd1;
    localparam t_func FUNC_QUERY  = 2'd2;
    localparam t_func FUNC_TICK   = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_DUPLICATE = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef struct packed {
        t_func              func;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               fired;
        logic [ID_W-1:0]    fired_id;
        logic               present;
        logic [CNT_W-1:0]   pending_count;
        logic               last;
    } t_out_item;

endpackage

// ===== src/multi_timer_event_queue_core.sv =====
// A query scans every pending entry and then shows its result; add and remove then
//   move table entries through the table RAM's read and write ports.
// Tick: advances the tick count, then fires head entries while they have expired, one beat each, the last marked.
// Commands run one at a time; start is taken again in the cycle the last beat shows.
// Each result beat is shown for one cycle on o_strobe; the receiver cannot stall it.
// Reset (synchronous, active low) empties the table and clears the tick count to zero.
`timescale 1ns / 1ps

module multi_timer_event_queue_core #(
    parameter int DEPTH     = mtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = mtq_pkg::TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  mtq_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output mtq_pkg::t_out_item o_result
);
    import mtq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_TRD    = 3'd5;
    localparam logic [2:0] S_TCHK   = 3'd6;

    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [ID_W-1:0]      ident;
    } t_slot;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, l};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt5(input logic [CW-1:0] c);
        logic [CW+CNT_W-1:0] t;
        t = {{CNT_W{1'b0}}, c};
        return t[CNT_W-1:0];
    endfunction

    function automatic t_out_item mk(input t_status st, input logic fd,
                                     input logic [ID_W-1:0] fid, input logic pr,
                                     input logic [CW-1:0] c, input logic lst);
        t_out_item r;
        r.status        = st;
        r.fired         = fd;
        r.fired_id      = fid;
        r.present       = pr;
        r.pending_count = cnt5(c);
        r.last          = lst;
        return r;
    endfunction

    // control state
    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_head, n_head;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                 r_pv, n_pv;
    logic                 r_held_v, n_held_v;
    logic                 r_stb, n_stb;

    // payload
    t_func                r_func, n_func;
    logic [ID_W-1:0]      r_id, n_id;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic [CW-1:0]        r_iss, n_iss;
    logic [CW-1:0]        r_pidx, n_pidx;
    logic [IW-1:0]        r_pdst, n_pdst;
    logic                 r_found, n_found;
    logic [CW-1:0]        r_pos, n_pos;
    logic                 r_ins_set, n_ins_set;
    logic [CW-1:0]        r_ins, n_ins;
    logic [CW-1:0]        r_src, n_src;
    logic [CW-1:0]        r_left, n_left;
    logic [ID_W-1:0]      r_held_id, n_held_id;
    logic [CW-1:0]        r_held_cnt, n_held_cnt;
    t_out_item            r_out, n_out;

    t_slot                r_mem [DEPTH];
    t_slot                r_rd;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    t_slot                wr_data;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] age;
    t_out_item            tick_final;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign rem = r_rd.expiry - r_now;
    assign age = r_now - r_rd.expiry;

    always_comb begin
        if (r_held_v) begin
            tick_final = mk(ST_OK, 1'b1, r_held_id, 1'b0, r_held_cnt, 1'b1);
        end else begin
            tick_final = mk(ST_OK, 1'b0, '0, 1'b0, r_count, 1'b1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_now      = r_now;
        n_pv       = r_pv;
        n_held_v   = r_held_v;
        n_stb      = 1'b0;
        n_func     = r_func;
        n_id       = r_id;
        n_delay    = r_delay;
        n_iss      = r_iss;
        n_pidx     = r_pidx;
        n_pdst     = r_pdst;
        n_found    = r_found;
        n_pos      = r_pos;
        n_ins_set  = r_ins_set;
        n_ins      = r_ins;
        n_src      = r_src;
        n_left     = r_left;
        n_held_id  = r_held_id;
        n_held_cnt = r_held_cnt;
        n_out      = r_out;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        wr_en      = 1'b0;
        wr_addr    = r_pdst;
        wr_data    = r_rd;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func    = i_item.func;
                    n_id      = i_item.timer_id;
                    n_delay   = i_item.delay;
                    n_iss     = '0;
                    n_pv      = 1'b0;
                    n_found   = 1'b0;
                    n_ins_set = 1'b0;
                    n_ins     = r_count;
                    n_held_v  = 1'b0;
                    if (i_item.func == FUNC_TICK) begin
                        n_now   = r_now + TIME_BITS'(1);
                        n_state = S_TRD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // read one slot per cycle, compare the one read the cycle before
                if (r_pv) begin
                    if (r_rd.ident == r_id && !r_found) begin
                        n_found = 1'b1;
                        n_pos   = r_pidx;
                    end
                    if (r_func == FUNC_ADD && !r_ins_set && rem > TIME_BITS'(r_delay)) begin
                        n_ins_set = 1'b1;
                        n_ins     = r_pidx;
                    end
                end
                if (r_iss != r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = phys(r_head, r_iss);
                    n_iss   = r_iss + CW'(1);
                    n_pidx  = r_iss;
                    n_pv    = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                case (r_func)
                    FUNC_QUERY: begin
                        n_out   = mk(ST_OK, 1'b0, '0, r_found, r_count, 1'b1);
                        n_stb   = 1'b1;
                        n_state = S_IDLE;
                    end
                    FUNC_ADD: begin
                        if (r_found) begin
                            n_out   = mk(ST_DUPLICATE, 1'b0, '0, 1'b0, r_count, 1'b1);
                            n_stb   = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_out   = mk(ST_FULL, 1'b0, '0, 1'b0, r_count, 1'b1);
                            n_stb   = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            // open a gap at the insertion point, moving from the tail
                            n_src   = r_count - CW'(1);
                            n_left  = r_count - r_ins;
                            n_state = S_SHIFT;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!r_found) begin
                            n_out   = mk(ST_NOT_FOUND, 1'b0, '0, 1'b0, r_count, 1'b1);
                            n_stb   = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_src   = r_pos + CW'(1);
                            n_left  = r_count - r_pos - CW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SHIFT: begin
                if (r_pv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pdst;
                    wr_data = r_rd;
                end
                if (r_left != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = phys(r_head, r_src);
                    n_pv    = 1'b1;
                    n_left  = r_left - CW'(1);
                    if (r_func == FUNC_ADD) begin
                        n_pdst = phys(r_head, r_src + CW'(1));
                        n_src  = r_src - CW'(1);
                    end else begin
                        n_pdst = phys(r_head, r_src - CW'(1));
                        n_src  = r_src + CW'(1);
                    end
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (r_func == FUNC_ADD) begin
                    wr_en          = 1'b1;
                    wr_addr        = phys(r_head, r_ins);
                    wr_data.expiry = r_now + TIME_BITS'(r_delay);
                    wr_data.ident  = r_id;
                    n_count        = r_count + CW'(1);
                    n_out          = mk(ST_OK, 1'b0, '0, 1'b0, r_count + CW'(1), 1'b1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_out   = mk(ST_OK, 1'b0, '0, 1'b0, r_count - CW'(1), 1'b1);
                end
                n_stb   = 1'b1;
                n_state = S_IDLE;
            end

            S_TRD: begin
                if (r_count == '0) begin
                    n_out   = tick_final;
                    n_stb   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = S_TCHK;
                end
            end

            S_TCHK: begin
                // hold each fired entry back one step so the final beat can carry last
                if (!age[TIME_BITS-1]) begin
                    if (r_held_v) begin
                        n_out = mk(ST_OK, 1'b1, r_held_id, 1'b0, r_held_cnt, 1'b0);
                        n_stb = 1'b1;
                    end
                    n_held_v   = 1'b1;
                    n_held_id  = r_rd.ident;
                    n_held_cnt = r_count - CW'(1);
                    n_count    = r_count - CW'(1);
                    n_head     = phys(r_head, CW'(1));
                    n_state    = S_TRD;
                end else begin
                    n_out   = tick_final;
                    n_stb   = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_now    <= '0;
            r_pv     <= 1'b0;
            r_held_v <= 1'b0;
            r_stb    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_now    <= n_now;
            r_pv     <= n_pv;
            r_held_v <= n_held_v;
            r_stb    <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_id       <= n_id;
        r_delay    <= n_delay;
        r_iss      <= n_iss;
        r_pidx     <= n_pidx;
        r_pdst     <= n_pdst;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_ins_set  <= n_ins_set;
        r_ins      <= n_ins;
        r_src      <= n_src;
        r_left     <= n_left;
        r_held_id  <= n_held_id;
        r_held_cnt <= n_held_cnt;
        r_out      <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule

// ===== src/mtq_checker.sv =====
`timescale 1ns / 1ps

module mtq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input mtq_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_strobe,
    input mtq_pkg::t_out_item o_result
);
    import mtq_pkg::*;

    // an accepted command keeps the block occupied
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // the final beat of a command leaves the block free
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("busy still high on final beat");

    // a non-final beat only comes from a tick still draining expired entries
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (busy && o_result.fired))
        else $error("non-final beat outside a tick drain");

    // an expired-timer beat is never an error or a query answer
    a_fired_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.fired) |-> (o_result.status == ST_OK && !o_result.present))
        else $error("fired beat carries status or presence");

    // a result comes only out of a command in progress
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a command in progress");

endmodule

bind multi_timer_event_queue_core mtq_checker u_mtq_checker (.*);

// ===== tb/multi_timer_event_queue_core_test.sv =====
`timescale 1ns / 1ps

module multi_timer_event_queue_core_test;
    import mtq_pkg::*;

    localparam int NUM_SLOTS   = DEPTH_DEF;
    localparam int RAND_ITEMS  = 240;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 60;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    multi_timer_event_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the timer table, sorted by expiry
    logic [TIME_BITS_DEF-1:0] shadow_expiry [NUM_SLOTS];
    logic [ID_W-1:0]          shadow_ident  [NUM_SLOTS];
    int                       shadow_count = 0;
    logic [TIME_BITS_DEF-1:0] shadow_now   = '0;

    t_out_item due_beats [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    t_row directed_rows [$];

    function automatic int find_timer(input logic [ID_W-1:0] id);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_ident[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_out_item make_beat(input t_status st, input logic fired,
                                            input logic [ID_W-1:0] fid,
                                            input logic present, input logic last);
        t_out_item b;
        b.status        = st;
        b.fired         = fired;
        b.fired_id      = fid;
        b.present       = present;
        b.pending_count = shadow_count[CNT_W-1:0];
        b.last          = last;
        return b;
    endfunction

    function automatic void drop_timer(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_expiry[i] = shadow_expiry[i+1];
            shadow_ident[i]  = shadow_ident[i+1];
        end
        shadow_count--;
    endfunction

    function automatic void predict_timer_op(input t_in_item it, ref t_out_item res[$]);
        int                       pos;
        int                       ins;
        int                       fires;
        logic [TIME_BITS_DEF-1:0] remain;
        logic [TIME_BITS_DEF-1:0] overdue;
        t_out_item                held;
        logic [ID_W-1:0]          fid;
        res = {};
        case (it.func)
            FUNC_ADD: begin
                if (find_timer(it.timer_id) >= 0) begin
                    res.push_back(make_beat(ST_DUPLICATE, 1'b0, '0, 1'b0, 1'b1));
                end else if (shadow_count >= NUM_SLOTS) begin
                    res.push_back(make_beat(ST_FULL, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    ins = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        remain = shadow_expiry[i] - shadow_now;
                        if (remain > {{(TIME_BITS_DEF-DELAY_W){1'b0}}, it.delay}) begin
                            ins = i;
                            break;
                        end
                    end
                    for (int i = shadow_count; i > ins; i--) begin
                        shadow_expiry[i] = shadow_expiry[i-1];
                        shadow_ident[i]  = shadow_ident[i-1];
                    end
                    shadow_expiry[ins] = shadow_now + TIME_BITS_DEF'(it.delay);
                    shadow_ident[ins]  = it.timer_id;
                    shadow_count++;
                    res.push_back(make_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                end
            end
            FUNC_REMOVE: begin
                pos = find_timer(it.timer_id);
                if (pos < 0) begin
                    res.push_back(make_beat(ST_NOT_FOUND, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    drop_timer(pos);
                    res.push_back(make_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                end
            end
            FUNC_QUERY: begin
                res.push_back(make_beat(ST_OK, 1'b0, '0, find_timer(it.timer_id) >= 0,
                                        1'b1));
            end
            default: begin
                shadow_now = shadow_now + TIME_BITS_DEF'(1);
                fires = 0;
                // hold each fired beat back one step so the final one can take last
                while (shadow_count > 0) begin
                    overdue = shadow_now - shadow_expiry[0];
                    if (overdue[TIME_BITS_DEF-1]) begin
                        break;
                    end
                    fid = shadow_ident[0];
                    drop_timer(0);
                    if (fires > 0) begin
                        res.push_back(held);
                    end
                    held = make_beat(ST_OK, 1'b1, fid, 1'b0, 1'b0);
                    fires++;
                end
                if (fires == 0) begin
                    res.push_back(make_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    held.last = 1'b1;
                    res.push_back(held);
                end
            end
        endcase
    endfunction

    function automatic void add_row(input t_func f, input logic [ID_W-1:0] id,
                                    input logic [DELAY_W-1:0] dly, input bit typed,
                                    input t_out_item want);
        t_row r;
        r.item.func     = f;
        r.item.timer_id = id;
        r.item.delay    = dly;
        r.typed         = typed;
        r.want          = want;
        directed_rows.push_back(r);
    endfunction

    task automatic send_beat(input t_in_item it, input int gap, input bit typed,
                             input t_out_item want);
        t_out_item predicted [$];
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_timer_op(it, predicted);
        if (typed) begin
            due_beats.push_back(want);
        end else begin
            foreach (predicted[k]) due_beats.push_back(predicted[k]);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected result beat expected none got %h", $time,
                         o_result);
                mismatch_count++;
            end else begin
                want = due_beats.pop_front();
                check_field("status", want.status, o_result.status);
                check_field("fired", want.fired, o_result.fired);
                check_field("fired_id", want.fired_id, o_result.fired_id);
                check_field("present", want.present, o_result.present);
                check_field("pending_count", want.pending_count, o_result.pending_count);
                check_field("last", want.last, o_result.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        logic [4:0] idx;
        if ($urandom_range(0, 99) < 20) begin
            return ID_W'($urandom);
        end
        idx = 5'($urandom_range(0, 23));
        return {idx, 6'b0, idx};
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return DELAY_W'($urandom_range(0, 30));
        if (roll < 80) return DELAY_W'($urandom_range(0, 3));
        if (roll < 88) return DELAY_W'($urandom);
        if (roll < 94) return '1;
        return '0;
    endfunction

    function automatic t_func pick_func();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return FUNC_ADD;
        if (roll < 70) return FUNC_TICK;
        if (roll < 88) return FUNC_REMOVE;
        return FUNC_QUERY;
    endfunction

    initial begin
        t_in_item  it;
        t_out_item none;
        int        gap;
        none = '0;

        // empty table, idle tick, removal of an absent timer, then a first add and its duplicate
        add_row(FUNC_QUERY,  16'h0000, 24'h000000, 1, '{ST_OK, 1'b0, 16'h0, 1'b0, 5'd0, 1'b1});
        add_row(FUNC_TICK,   16'hFFFF, 24'hFFFFFF, 1, '{ST_OK, 1'b0, 16'h0, 1'b0, 5'd0, 1'b1});
        add_row(FUNC_REMOVE, 16'h1234, 24'h000000, 1,
                '{ST_NOT_FOUND, 1'b0, 16'h0, 1'b0, 5'd0, 1'b1});
        add_row(FUNC_ADD,    16'h0000, 24'h000000, 1, '{ST_OK, 1'b0, 16'h0, 1'b0, 5'd1, 1'b1});
        add_row(FUNC_ADD,    16'h0000, 24'h000005, 1,
                '{ST_DUPLICATE, 1'b0, 16'h0, 1'b0, 5'd1, 1'b1});
        // equal expiry keeps insertion order; delays of zero and one fire together
        add_row(FUNC_ADD,    16'h0002, 24'h000001, 0, none);
        add_row(FUNC_ADD,    16'h0001, 24'h000000, 0, none);
        add_row(FUNC_QUERY,  16'h0000, 24'h000000, 0, none);
        add_row(FUNC_TICK,   16'h0000, 24'h000000, 0, none);
        // fill the table, then overflow it and try a duplicate on a full table
        add_row(FUNC_ADD,    16'hFFFF, 24'hFFFFFF, 0, none);
        for (int k = 1; k < NUM_SLOTS; k++) begin
            add_row(FUNC_ADD, ID_W'(k * 16'h0F0F), DELAY_W'((k - 1) * 3), 0, none);
        end
        add_row(FUNC_ADD,    16'h4242, 24'h000001, 1, '{ST_FULL, 1'b0, 16'h0, 1'b0, 5'd16, 1'b1});
        add_row(FUNC_ADD,    16'hFFFF, 24'h000001, 1,
                '{ST_DUPLICATE, 1'b0, 16'h0, 1'b0, 5'd16, 1'b1});
        add_row(FUNC_TICK,   16'h0000, 24'h000000, 0, none);
        add_row(FUNC_REMOVE, 16'hFFFF, 24'h000000, 0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            gap = (r % 3 == 0) ? $urandom_range(0, 17) : 0;
            send_beat(directed_rows[r].item, gap, directed_rows[r].typed,
                      directed_rows[r].want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                start <= 1'b0;
                while (due_beats.size() != 0) @(posedge i_clk);
            end
            it.func     = pick_func();
            it.timer_id = pick_id();
            it.delay    = pick_delay();
            // back-to-back stretches between idle ones
            gap = (n % 60 < 15) ? 0 : $urandom_range(0, 17);
            send_beat(it, gap, 0, none);
        end
        start <= 1'b0;

        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mtq_pkg.sv
src/multi_timer_event_queue_core.sv
src/mtq_checker.sv
tb/multi_timer_event_queue_core_test.sv
